[design/aabb_pkg.sv]
// Shared types and constants for the AABB pair collision detector.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package aabb_pkg;

  localparam int unsigned MAX_BOXES_DEFAULT = 64;
  localparam int unsigned QUEUE_DEPTH       = 2;

  localparam int unsigned ID_W    = 16;
  localparam int unsigned POS_W   = 16;
  localparam int unsigned SIZE_W  = 15;
  localparam int unsigned COORD_W = 18;

  // At most this many results per box; the last one kept carries last = 1.
  localparam int unsigned RESULT_CAP = 63;
  localparam int unsigned HIT_W      = 6;

  typedef struct packed {
    logic                     new_frame;
    logic [ID_W-1:0]          entity_id;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  off_x;
    logic signed [POS_W-1:0]  off_y;
    logic [SIZE_W-1:0]        size_x;
    logic [SIZE_W-1:0]        size_y;
  } in_t;

  typedef struct packed {
    logic [ID_W-1:0] first_entity;
    logic [ID_W-1:0] second_entity;
    logic            store_full;
    logic            last;
  } out_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] max_y;
    logic [ID_W-1:0]           entity;
  } box_t;

  localparam int unsigned BOX_W = $bits(box_t);

endpackage

[design/aabb_front.sv]
// Front end: accepts input transactions, forms box extents and assigns store slots.
// Depends on aabb_pkg.
`timescale 1ns / 1ps

module aabb_front import aabb_pkg::*; #(
  parameter int unsigned MAX_BOXES = MAX_BOXES_DEFAULT,
  localparam int unsigned CNT_W    = $clog2(MAX_BOXES + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_t              in_data_i,
  input  logic             q_full_i,
  output logic             push_o,
  output box_t             box_o,
  output logic [CNT_W-1:0] cnt_o,
  output logic             full_o
);

  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] n;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // Boxes already in the frame that this one is tested against
  assign n      = in_data_i.new_frame ? '0 : count_q;
  assign full_o = (n == CNT_W'(MAX_BOXES));
  assign cnt_o  = n;

  always_comb begin
    box_o.min_x  = {{(COORD_W-POS_W){in_data_i.pos_x[POS_W-1]}}, in_data_i.pos_x}
                 + {{(COORD_W-POS_W){in_data_i.off_x[POS_W-1]}}, in_data_i.off_x};
    box_o.min_y  = {{(COORD_W-POS_W){in_data_i.pos_y[POS_W-1]}}, in_data_i.pos_y}
                 + {{(COORD_W-POS_W){in_data_i.off_y[POS_W-1]}}, in_data_i.off_y};
    box_o.max_x  = box_o.min_x + {{(COORD_W-SIZE_W){1'b0}}, in_data_i.size_x};
    box_o.max_y  = box_o.min_y + {{(COORD_W-SIZE_W){1'b0}}, in_data_i.size_y};
    box_o.entity = in_data_i.entity_id;
  end

  always_comb begin
    count_d = count_q;
    if (push_o) begin
      count_d = full_o ? n : n + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

[design/aabb_queue.sv]
// Small FIFO between the front end and the sweep engine.
// Depends on aabb_pkg for the default depth.
`timescale 1ns / 1ps

module aabb_queue import aabb_pkg::*; #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = QUEUE_DEPTH,
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned LVL_W = $clog2(DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] entry_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [LVL_W-1:0]  level_q, level_d;

  assign full_o  = (level_q == LVL_W'(DEPTH));
  assign valid_o = (level_q != '0);
  assign rdata_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    level_d  = level_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      level_d = level_q + LVL_W'(1);
    end else if (pop_i && !push_i) begin
      level_d = level_q - LVL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

[design/aabb_back.sv]
// Back end: box store, sweep over stored boxes (one per cycle unless the output stalls), result register.
// Depends on aabb_pkg.
`timescale 1ns / 1ps

module aabb_back import aabb_pkg::*; #(
  parameter int unsigned MAX_BOXES = MAX_BOXES_DEFAULT,
  localparam int unsigned CNT_W    = $clog2(MAX_BOXES + 1),
  localparam int unsigned IDX_W    = $clog2(MAX_BOXES)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  input  box_t             cmd_box_i,
  input  logic [CNT_W-1:0] cmd_cnt_i,
  input  logic             cmd_full_i,
  output logic             cmd_pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_t             out_data_o
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SWEEP  = 3'b010,
    ST_FINISH = 3'b100
  } state_e;

  state_e           state_q, state_d;
  box_t             mem_q [MAX_BOXES];
  box_t             rd_q;
  logic             b_vld_q;
  logic [CNT_W-1:0] idx_q;
  logic             p_vld_q;
  logic [ID_W-1:0]  p_first_q;
  logic [HIT_W-1:0] hit_cnt_q;
  logic             out_vld_q;
  out_t             out_q;

  logic out_free, hit_x, hit_y, hit_eff, b_adv, a_fire, sweep_done;
  logic fin_fire, emit_mid, emit_last, start;

  assign out_free = !out_vld_q || !out_stall_i;

  assign hit_x   = (cmd_box_i.min_x <= rd_q.max_x) && (cmd_box_i.max_x >= rd_q.min_x);
  assign hit_y   = (cmd_box_i.min_y <= rd_q.max_y) && (cmd_box_i.max_y >= rd_q.min_y);
  // hits past the cap are dropped
  assign hit_eff = hit_x && hit_y && (hit_cnt_q != HIT_W'(RESULT_CAP));

  // The newest hit is held back until the next hit or the end of the sweep, so the final one can carry last.
  assign b_adv      = b_vld_q && (!hit_eff || !p_vld_q || out_free);
  assign a_fire     = (state_q == ST_SWEEP) && (idx_q != cmd_cnt_i) && (!b_vld_q || b_adv);
  assign sweep_done = (state_q == ST_SWEEP) && (idx_q == cmd_cnt_i) && !b_vld_q;
  assign fin_fire   = (state_q == ST_FINISH) && (!p_vld_q || out_free);
  assign start      = (state_q == ST_IDLE) && cmd_valid_i;
  assign emit_mid   = b_adv && hit_eff && p_vld_q;
  assign emit_last  = fin_fire && p_vld_q;
  assign cmd_pop_o  = fin_fire;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) state_d = ST_SWEEP;
      end
      ST_SWEEP: begin
        if (sweep_done) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (fin_fire) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      b_vld_q   <= 1'b0;
      p_vld_q   <= 1'b0;
      hit_cnt_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (start) begin
        idx_q <= '0;
      end else if (a_fire) begin
        idx_q <= idx_q + CNT_W'(1);
      end
      if (a_fire) begin
        b_vld_q <= 1'b1;
      end else if (b_adv) begin
        b_vld_q <= 1'b0;
      end
      if (fin_fire) begin
        p_vld_q <= 1'b0;
      end else if (b_adv && hit_eff) begin
        p_vld_q <= 1'b1;
      end
      if (start) begin
        hit_cnt_q <= '0;
      end else if (b_adv && hit_eff) begin
        hit_cnt_q <= hit_cnt_q + HIT_W'(1);
      end
      if (out_free) begin
        out_vld_q <= emit_mid || emit_last;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_adv && hit_eff) begin
      p_first_q <= rd_q.entity;
    end
    if (out_free && (emit_mid || emit_last)) begin
      out_q.first_entity  <= p_first_q;
      out_q.second_entity <= cmd_box_i.entity;
      out_q.store_full    <= cmd_full_i;
      out_q.last          <= emit_last;
    end
  end

  // Box store: one read per stored box swept, one write per retired box unless the store is full
  always_ff @(posedge clk_i) begin
    if (a_fire) begin
      rd_q <= mem_q[idx_q[IDX_W-1:0]];
    end
    if (fin_fire && !cmd_full_i) begin
      mem_q[cmd_cnt_i[IDX_W-1:0]] <= cmd_box_i;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

[design/aabb_pair_collision_detector.sv]
// AABB pair collision detector, 2D, fixed point with 4 fraction bits.
//
// Input channel (in_valid_i / in_stall_o / in_data_i): one box per transaction.
// A transaction is taken at a clock edge with valid high and stall low.
// new_frame empties the box store before the box is handled.
// Output channel (out_valid_o / out_stall_i / out_data_o): one transaction per
// overlapping pair (stored id, new id), in store order; last marks the final
// pair of a box. A box with no overlap produces nothing.
// A box tested against n stored boxes holds the sweep engine while it reads
// the store, one stored box per cycle unless the output stalls; with an empty
// store it only passes through the engine.
// A pair is held until the next overlapping box or the end of the sweep, so
// with a single overlap the result leaves only when the sweep ends. A two-entry
// queue takes further boxes during a sweep, so the input can accept new boxes
// before the sweep of the last one is through; in_stall_o rises when it is full.
// While out_stall_i is high the result register holds and the sweep pauses at
// the next overlapping box. Reset empties the store count, the queue and the
// result register; store contents are not cleared.
// Depends on aabb_pkg, aabb_front, aabb_queue, aabb_back.
`timescale 1ns / 1ps

module aabb_pair_collision_detector import aabb_pkg::*; #(
  parameter int unsigned MAX_BOXES = MAX_BOXES_DEFAULT
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam int unsigned CNT_W  = $clog2(MAX_BOXES + 1);
  localparam int unsigned QDAT_W = BOX_W + CNT_W + 1;

  logic              q_full, q_push, q_valid, q_pop;
  box_t              f_box;
  logic [CNT_W-1:0]  f_cnt;
  logic              f_full;
  logic [QDAT_W-1:0] q_rdata;

  aabb_front #(.MAX_BOXES(MAX_BOXES)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .box_o      (f_box),
    .cnt_o      (f_cnt),
    .full_o     (f_full)
  );

  aabb_queue #(.DATA_W(QDAT_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i ({f_box, f_cnt, f_full}),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_rdata)
  );

  aabb_back #(.MAX_BOXES(MAX_BOXES)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_box_i   (box_t'(q_rdata[QDAT_W-1 -: BOX_W])),
    .cmd_cnt_i   (q_rdata[CNT_W:1]),
    .cmd_full_i  (q_rdata[0]),
    .cmd_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

[design/aabb_checker.sv]
// Port-level checks for the AABB pair collision detector, bound to the top level.
// Depends on aabb_pkg.
`timescale 1ns / 1ps

module aabb_checker import aabb_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input in_t  in_data_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  logic            open_q;
  logic [ID_W-1:0] second_q;
  logic            full_q;

  // Tracks the box whose group of results is still running
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q   <= 1'b0;
      second_q <= '0;
      full_q   <= 1'b0;
    end else if (out_valid_o && !out_stall_i) begin
      open_q   <= !out_data_o.last;
      second_q <= out_data_o.second_entity;
      full_q   <= out_data_o.store_full;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result transaction changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && open_q |->
      (out_data_o.second_entity == second_q) && (out_data_o.store_full == full_q))
    else $error("result group mixes boxes");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !out_valid_o && !in_stall_o)
    else $error("block not empty after reset");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("stalled input transaction changed");

endmodule

bind aabb_pair_collision_detector aabb_checker u_aabb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

[bench/aabb_pair_collision_detector_tb.sv]
// Self-checking bench for aabb_pair_collision_detector: boxes are driven from a backlog,
// colliding pairs are predicted in-bench and checked against every output transaction.
// Depends on aabb_pkg and the detector RTL.
`timescale 1ns / 1ps

module aabb_pair_collision_detector_tb;
  import aabb_pkg::*;

  localparam int unsigned MAX_BOXES = MAX_BOXES_DEFAULT;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_stall_o;
  in_t  in_data_i   = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  aabb_pair_collision_detector #(
    .MAX_BOXES(MAX_BOXES)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  in_t         box_backlog[$];
  out_t        expected_pairs[$];
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned mismatches    = 0;

  // Bench copy of the box store
  logic signed [COORD_W-1:0] held_min_x[MAX_BOXES];
  logic signed [COORD_W-1:0] held_min_y[MAX_BOXES];
  logic signed [COORD_W-1:0] held_max_x[MAX_BOXES];
  logic signed [COORD_W-1:0] held_max_y[MAX_BOXES];
  logic [ID_W-1:0]           held_id[MAX_BOXES];
  logic [6:0]                held_count = '0;

  function automatic logic signed [COORD_W-1:0] widen(input logic [POS_W-1:0] v);
    return {{(COORD_W-POS_W){v[POS_W-1]}}, v};
  endfunction

  task automatic predict_pairs(input in_t box);
    logic signed [COORD_W-1:0] mnx, mny, mxx, mxy;
    int unsigned hits;
    logic full;
    out_t pair;
    mnx  = widen(box.pos_x) + widen(box.off_x);
    mny  = widen(box.pos_y) + widen(box.off_y);
    mxx  = mnx + {{(COORD_W-SIZE_W){1'b0}}, box.size_x};
    mxy  = mny + {{(COORD_W-SIZE_W){1'b0}}, box.size_y};
    if (box.new_frame) held_count = '0;
    full = (held_count >= MAX_BOXES);
    hits = 0;
    for (int k = 0; k < held_count && hits < RESULT_CAP; k++) begin
      if (mnx <= held_max_x[k] && mxx >= held_min_x[k] &&
          mny <= held_max_y[k] && mxy >= held_min_y[k]) begin
        pair.first_entity  = held_id[k];
        pair.second_entity = box.entity_id;
        pair.store_full    = full;
        pair.last          = 1'b0;
        expected_pairs.push_back(pair);
        hits++;
      end
    end
    if (hits > 0) begin
      pair      = expected_pairs.pop_back();
      pair.last = 1'b1;
      expected_pairs.push_back(pair);
    end
    if (!full) begin
      held_min_x[held_count] = mnx;
      held_min_y[held_count] = mny;
      held_max_x[held_count] = mxx;
      held_max_y[held_count] = mxy;
      held_id[held_count]    = box.entity_id;
      held_count             = held_count + 7'd1;
    end
  endtask

  task automatic check_pair(input out_t got);
    out_t want;
    if (expected_pairs.size() == 0) begin
      if (mismatches < 50)
        $display("%0t: unexpected pair first=%h second=%h full=%b last=%b", $time,
                 got.first_entity, got.second_entity, got.store_full, got.last);
      mismatches++;
    end else begin
      want = expected_pairs.pop_front();
      if (got.first_entity !== want.first_entity || got.second_entity !== want.second_entity ||
          got.store_full !== want.store_full || got.last !== want.last) begin
        if (mismatches < 50)
          $display("%0t: pair mismatch, expected %h/%h full=%b last=%b, got %h/%h full=%b last=%b",
                   $time, want.first_entity, want.second_entity, want.store_full, want.last,
                   got.first_entity, got.second_entity, got.store_full, got.last);
        mismatches++;
      end
    end
  endtask

  // Driver: next box once the current transaction has gone through
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (box_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        in_data_i  <= box_backlog.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Monitor: check results before predicting, so ordering within the edge is fixed
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) check_pair(out_data_o);
      if (in_valid_i && !in_stall_o) predict_pairs(in_data_i);
    end
  end

  task automatic push_box(input bit nf, input int id, input int px, input int py,
                          input int ox, input int oy, input int sx, input int sy);
    in_t box;
    box.new_frame = nf;
    box.entity_id = id[ID_W-1:0];
    box.pos_x     = px[POS_W-1:0];
    box.pos_y     = py[POS_W-1:0];
    box.off_x     = ox[POS_W-1:0];
    box.off_y     = oy[POS_W-1:0];
    box.size_x    = sx[SIZE_W-1:0];
    box.size_y    = sy[SIZE_W-1:0];
    box_backlog.push_back(box);
  endtask

  function automatic int jitter(input int unsigned s);
    return int'($urandom_range(2 * s)) - int'(s);
  endfunction

  // One frame of boxes scattered around a common centre
  task automatic push_cluster(input int unsigned n, input int unsigned s);
    int cx, cy;
    cx = $urandom_range(65535);
    cy = $urandom_range(65535);
    for (int unsigned k = 0; k < n; k++)
      push_box(k == 0, $urandom_range(65535), cx + jitter(s), cy + jitter(s),
               jitter(s), jitter(s), $urandom_range(2 * s), $urandom_range(2 * s));
  endtask

  task automatic push_random(input int unsigned count);
    int unsigned made, len, s;
    made = 0;
    while (made < count) begin
      if ($urandom_range(4) == 0) begin
        push_box($urandom_range(7) == 0, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom_range(32767), $urandom_range(32767));
        made++;
      end else begin
        case ($urandom_range(3))
          0:       s = 4;
          1:       s = 40;
          2:       s = 400;
          default: s = 6000;
        endcase
        len = $urandom_range(2, 10);
        push_cluster(len, s);
        made += len;
      end
    end
  endtask

  // Chain of 64 boxes touching neighbours, boxes against the full store, a new frame
  task automatic push_full_store();
    int bx, by;
    bx = int'($urandom_range(20000)) - 10000;
    by = int'($urandom_range(20000)) - 10000;
    for (int k = 0; k < MAX_BOXES; k++)
      push_box(k == 0, $urandom_range(65535), bx + 32 * k, by, 0, $urandom_range(15), 40, 16);
    push_box(1'b0, $urandom_range(65535), bx - 8, by, 0, 0, 32 * MAX_BOXES + 48, 40);
    push_box(1'b0, $urandom_range(65535), bx + 100, by + 8, 0, 0, 40, 0);
    push_box(1'b0, $urandom_range(65535), bx, by + 500, 0, 0, 4, 4);
    push_box(1'b1, $urandom_range(65535), bx, by, 0, 0, 8, 8);
  endtask

  task automatic wait_drained();
    while (box_backlog.size() != 0 || in_valid_i || expected_pairs.size() != 0)
      @(negedge clk_i);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: overlap, containment, edge and corner contact, points, segments,
    // coordinate extremes and frame clearing
    push_box(1'b1, 16'h0001, 0, 0, 0, 0, 16, 16);
    push_box(1'b0, 16'h0002, 8, 8, 0, 0, 4, 4);
    push_box(1'b0, 16'h0003, 16, 0, 0, 0, 16, 16);
    push_box(1'b0, 16'h0004, 33, 0, 0, 0, 0, 0);
    push_box(1'b0, 16'h0005, 32, 16, 0, 0, 0, 0);
    push_box(1'b0, 16'h0006, 100, 100, -200, -200, 300, 300);
    push_box(1'b0, 16'h0007, -1, -1, 0, 0, 0, 0);
    push_box(1'b1, 16'hFFFF, -32768, -32768, -32768, -32768, 0, 0);
    push_box(1'b0, 16'h0000, 32767, 32767, 32767, 32767, 32767, 32767);
    push_box(1'b0, 16'h8000, -32768, -32768, -32768, -32768, 32767, 32767);
    push_box(1'b0, 16'h7FFF, 32767, 32767, 32767, 32767, 0, 0);
    push_box(1'b0, 16'h1234, 0, 0, -32768, 32767, 32767, 0);
    push_box(1'b1, 16'h0100, -16, -16, 8, 8, 16, 16);
    push_box(1'b0, 16'h0101, 0, -100, 0, 0, 0, 200);
    push_box(1'b0, 16'h0102, -100, 0, 0, 0, 200, 0);
    push_box(1'b0, 16'h0103, 9, 9, 0, 0, 10, 10);
    push_box(1'b1, 16'h0200, -16, -16, 8, 8, 16, 16);
    push_box(1'b0, 16'h0201, -16, -16, 8, 8, 16, 16);
    push_random(20);
    wait_drained();

    send_idle_pct = 81;
    stall_pct     = 0;
    push_random(15);
    wait_drained();

    send_idle_pct = 0;
    stall_pct     = 81;
    push_full_store();
    push_random(10);
    wait_drained();

    send_idle_pct = 22;
    stall_pct     = 22;
    push_random(20);
    wait_drained();

    // Let any sweep still running finish, so stray pairs are caught
    repeat (250) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
